/* rtl/rpar_pkg.sv */
// Package for the raw pixel assemble and rotate block: register indexes, rotation codes,
// limits, the configuration bundle type and the range clamp functions.
// No dependencies.
package rpar_pkg;

    localparam int unsigned MAX_DIM             = 4096;
    localparam int unsigned MAX_SLICES          = 1024;
    localparam int unsigned MAX_BYTES_PER_PIXEL = 4;

    localparam int unsigned DIM_W   = 13;  // holds 1..MAX_DIM
    localparam int unsigned IDX_W   = 12;  // holds 0..MAX_DIM-1
    localparam int unsigned NSL_W   = 11;  // holds 1..MAX_SLICES
    localparam int unsigned SLC_W   = 10;  // holds 0..MAX_SLICES-1
    localparam int unsigned BPP_W   = 3;
    localparam int unsigned POS_W   = 2;
    localparam int unsigned HDR_W   = 16;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_HEADER_BYTES    = 3'd0,
        REG_BYTES_PER_PIXEL = 3'd1,
        REG_LITTLE_ENDIAN   = 3'd2,
        REG_IMAGE_WIDTH     = 3'd3,
        REG_IMAGE_HEIGHT    = 3'd4,
        REG_SLICE_TOTAL     = 3'd5,
        REG_ROTATION        = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        ROT_90  = 2'd0,
        ROT_180 = 2'd1,
        ROT_270 = 2'd2,
        ROT_ALT = 2'd3   // unused code, behaves as 90 degrees
    } rotation_t;

    // Effective settings handed from the register file to the datapath.
    typedef struct packed {
        logic [BPP_W-1:0] bpp;           // 1..4
        logic             little_endian;
        logic [DIM_W-1:0] width;         // 1..MAX_DIM
        logic [DIM_W-1:0] height;        // 1..MAX_DIM
        logic [NSL_W-1:0] slices;        // 1..MAX_SLICES
        rotation_t        rotation;
        logic             header_load;   // pulse on a header_bytes write
        logic [HDR_W-1:0] header_value;
    } cfg_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [NSL_W-1:0] clamp_slices(input logic [NSL_W-1:0] v);
        logic [NSL_W-1:0] r;
        if (v == '0)
            r = NSL_W'(1);
        else if (v > NSL_W'(MAX_SLICES))
            r = NSL_W'(MAX_SLICES);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] v);
        logic [BPP_W-1:0] r;
        if (v == '0)
            r = BPP_W'(1);
        else if (v > BPP_W'(MAX_BYTES_PER_PIXEL))
            r = BPP_W'(MAX_BYTES_PER_PIXEL);
        else
            r = v;
        return r;
    endfunction

endpackage

/* rtl/rpar_ifs.sv */
// Stream interfaces of the raw pixel assemble and rotate block: the byte input channel
// and the pixel output channel. Depends on rpar_pkg.
interface rpar_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rpar_pix_if;
    logic                              valid;
    logic                              ready;
    logic [rpar_pkg::PIX_W-1:0]        pixel_value;
    logic [rpar_pkg::SLC_W-1:0]        dest_slice;
    logic [rpar_pkg::IDX_W-1:0]        dest_outer;
    logic [rpar_pkg::IDX_W-1:0]        dest_inner;
    logic                              last_pixel;

    modport source (output valid, output pixel_value, output dest_slice, output dest_outer,
                    output dest_inner, output last_pixel, input ready);
    modport sink   (input valid, input pixel_value, input dest_slice, input dest_outer,
                    input dest_inner, input last_pixel, output ready);
endinterface

/* rtl/rpar_cfg.sv */
// APB-style configuration register file of the raw pixel assemble and rotate block.
// Depends on rpar_pkg.
module rpar_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpar_pkg::ADDR_W-1:0]   paddr,
    input  logic [rpar_pkg::DATA_W-1:0]   pwdata,
    output logic [rpar_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rpar_pkg::cfg_t                cfg
);

    logic [rpar_pkg::HDR_W-1:0] header_bytes_reg;
    logic [rpar_pkg::BPP_W-1:0] bytes_per_pixel_reg;
    logic                       little_endian_reg;
    logic [rpar_pkg::DIM_W-1:0] image_width_reg;
    logic [rpar_pkg::DIM_W-1:0] image_height_reg;
    logic [rpar_pkg::NSL_W-1:0] slice_total_reg;
    logic [1:0]                 rotation_reg;

    logic                       wr_en;
    rpar_pkg::reg_index_t       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = rpar_pkg::reg_index_t'(paddr[rpar_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg    <= '0;
            bytes_per_pixel_reg <= rpar_pkg::BPP_W'(2);
            little_endian_reg   <= 1'b0;
            image_width_reg     <= rpar_pkg::DIM_W'(512);
            image_height_reg    <= rpar_pkg::DIM_W'(512);
            slice_total_reg     <= rpar_pkg::NSL_W'(1);
            rotation_reg        <= rpar_pkg::ROT_90;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                rpar_pkg::REG_HEADER_BYTES:    header_bytes_reg    <= pwdata[rpar_pkg::HDR_W-1:0];
                rpar_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= pwdata[rpar_pkg::BPP_W-1:0];
                rpar_pkg::REG_LITTLE_ENDIAN:   little_endian_reg   <= pwdata[0];
                rpar_pkg::REG_IMAGE_WIDTH:     image_width_reg     <= pwdata[rpar_pkg::DIM_W-1:0];
                rpar_pkg::REG_IMAGE_HEIGHT:    image_height_reg    <= pwdata[rpar_pkg::DIM_W-1:0];
                rpar_pkg::REG_SLICE_TOTAL:     slice_total_reg     <= pwdata[rpar_pkg::NSL_W-1:0];
                rpar_pkg::REG_ROTATION:        rotation_reg        <= pwdata[1:0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            rpar_pkg::REG_HEADER_BYTES:    prdata = rpar_pkg::DATA_W'(header_bytes_reg);
            rpar_pkg::REG_BYTES_PER_PIXEL: prdata = rpar_pkg::DATA_W'(bytes_per_pixel_reg);
            rpar_pkg::REG_LITTLE_ENDIAN:   prdata = rpar_pkg::DATA_W'(little_endian_reg);
            rpar_pkg::REG_IMAGE_WIDTH:     prdata = rpar_pkg::DATA_W'(image_width_reg);
            rpar_pkg::REG_IMAGE_HEIGHT:    prdata = rpar_pkg::DATA_W'(image_height_reg);
            rpar_pkg::REG_SLICE_TOTAL:     prdata = rpar_pkg::DATA_W'(slice_total_reg);
            rpar_pkg::REG_ROTATION:        prdata = rpar_pkg::DATA_W'(rotation_reg);
            default:                       prdata = '0;
        endcase
    end

    // The datapath sees clamped values; the raw values stay readable.
    always_comb
    begin
        cfg.bpp           = rpar_pkg::clamp_bpp(bytes_per_pixel_reg);
        cfg.little_endian = little_endian_reg;
        cfg.width         = rpar_pkg::clamp_dim(image_width_reg);
        cfg.height        = rpar_pkg::clamp_dim(image_height_reg);
        cfg.slices        = rpar_pkg::clamp_slices(slice_total_reg);
        cfg.rotation      = rpar_pkg::rotation_t'(rotation_reg);
        cfg.header_load   = wr_en && (reg_sel == rpar_pkg::REG_HEADER_BYTES);
        cfg.header_value  = pwdata[rpar_pkg::HDR_W-1:0];
    end

endmodule

/* rtl/rpar_core.sv */
// Datapath of the raw pixel assemble and rotate block: header skip, byte packing,
// source counters, rotated address and the output register. Depends on rpar_pkg, rpar_ifs.
module rpar_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  rpar_pkg::cfg_t     cfg,
    rpar_byte_if.sink          byte_stream,
    rpar_pix_if.source         pixel_stream
);

    localparam int unsigned PIX_W = rpar_pkg::PIX_W;
    localparam int unsigned IDX_W = rpar_pkg::IDX_W;
    localparam int unsigned SLC_W = rpar_pkg::SLC_W;

    logic [rpar_pkg::HDR_W-1:0] header_left_reg,  header_left_next;
    logic [rpar_pkg::POS_W-1:0] byte_position_reg, byte_position_next;
    logic [PIX_W-1:0]           pixel_accum_reg,  pixel_accum_next;
    logic [SLC_W-1:0]           slice_count_reg,  slice_count_next;
    logic [IDX_W-1:0]           outer_count_reg,  outer_count_next;
    logic [IDX_W-1:0]           inner_count_reg,  inner_count_next;
    logic                       finished_reg,     finished_next;

    logic                       out_valid_reg,    out_valid_next;
    logic [PIX_W-1:0]           out_pixel_reg;
    logic [SLC_W-1:0]           out_slice_reg;
    logic [IDX_W-1:0]           out_outer_reg;
    logic [IDX_W-1:0]           out_inner_reg;
    logic                       out_last_reg;

    logic                       accept;
    logic                       in_payload;
    logic                       pixel_done;
    logic                       will_emit;
    logic                       emit;
    logic [PIX_W-1:0]           accum_base;
    logic [PIX_W-1:0]           accum_le;
    logic [IDX_W-1:0]           w_m1;
    logic [IDX_W-1:0]           h_m1;
    logic [IDX_W-1:0]           d_outer;
    logic [IDX_W-1:0]           d_inner;
    logic                       inner_wrap;
    logic                       outer_wrap;
    logic                       slice_wrap;

    // The decision to emit depends on state only, so bytes that cannot produce a pixel
    // keep flowing while a finished pixel waits downstream.
    assign in_payload = !finished_reg && (header_left_reg == '0);
    assign pixel_done = ({1'b0, byte_position_reg} + 3'd1) >= cfg.bpp;
    assign will_emit  = in_payload && pixel_done;

    assign byte_stream.ready = !will_emit || !out_valid_reg || pixel_stream.ready;
    assign accept            = byte_stream.valid && byte_stream.ready;
    assign emit              = accept && will_emit;

    assign accum_base = (byte_position_reg == '0) ? '0 : pixel_accum_reg;
    assign accum_le   = accum_base
                      | (PIX_W'(byte_stream.data_byte) << {byte_position_reg, 3'b000});

    assign w_m1 = IDX_W'(cfg.width  - rpar_pkg::DIM_W'(1));
    assign h_m1 = IDX_W'(cfg.height - rpar_pkg::DIM_W'(1));

    always_comb
    begin
        case (cfg.rotation)
            rpar_pkg::ROT_180:
            begin
                d_outer = w_m1 - outer_count_reg;
                d_inner = h_m1 - inner_count_reg;
            end
            rpar_pkg::ROT_270:
            begin
                d_outer = inner_count_reg;
                d_inner = w_m1 - outer_count_reg;
            end
            default:
            begin
                d_outer = h_m1 - inner_count_reg;
                d_inner = outer_count_reg;
            end
        endcase
    end

    assign inner_wrap = ({1'b0, inner_count_reg} + rpar_pkg::DIM_W'(1)) >= cfg.height;
    assign outer_wrap = ({1'b0, outer_count_reg} + rpar_pkg::DIM_W'(1)) >= cfg.width;
    assign slice_wrap = ({1'b0, slice_count_reg} + rpar_pkg::NSL_W'(1)) >= cfg.slices;

    always_comb
    begin
        header_left_next   = header_left_reg;
        byte_position_next = byte_position_reg;
        pixel_accum_next   = pixel_accum_reg;
        slice_count_next   = slice_count_reg;
        outer_count_next   = outer_count_reg;
        inner_count_next   = inner_count_reg;
        finished_next      = finished_reg;

        if (accept && !finished_reg)
        begin
            if (header_left_reg != '0)
            begin
                header_left_next = header_left_reg - rpar_pkg::HDR_W'(1);
            end
            else
            begin
                pixel_accum_next = cfg.little_endian ? accum_le
                                 : {accum_base[PIX_W-9:0], byte_stream.data_byte};
                if (!pixel_done)
                begin
                    byte_position_next = byte_position_reg + rpar_pkg::POS_W'(1);
                end
                else
                begin
                    byte_position_next = '0;
                    if (!inner_wrap)
                    begin
                        inner_count_next = inner_count_reg + IDX_W'(1);
                    end
                    else
                    begin
                        inner_count_next = '0;
                        if (!outer_wrap)
                        begin
                            outer_count_next = outer_count_reg + IDX_W'(1);
                        end
                        else
                        begin
                            outer_count_next = '0;
                            if (!slice_wrap)
                            begin
                                slice_count_next = slice_count_reg + SLC_W'(1);
                            end
                            else
                            begin
                                slice_count_next = '0;
                                finished_next    = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        // A header_bytes write restarts the skip count.
        if (cfg.header_load)
        begin
            header_left_next = cfg.header_value;
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (pixel_stream.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_left_reg   <= '0;
            byte_position_reg <= '0;
            pixel_accum_reg   <= '0;
            slice_count_reg   <= '0;
            outer_count_reg   <= '0;
            inner_count_reg   <= '0;
            finished_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            header_left_reg   <= header_left_next;
            byte_position_reg <= byte_position_next;
            pixel_accum_reg   <= pixel_accum_next;
            slice_count_reg   <= slice_count_next;
            outer_count_reg   <= outer_count_next;
            inner_count_reg   <= inner_count_next;
            finished_reg      <= finished_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pixel_reg <= pixel_accum_next;
            out_slice_reg <= slice_count_reg;
            out_outer_reg <= d_outer;
            out_inner_reg <= d_inner;
            out_last_reg  <= inner_wrap && outer_wrap && slice_wrap;
        end
    end

    assign pixel_stream.valid       = out_valid_reg;
    assign pixel_stream.pixel_value = out_pixel_reg;
    assign pixel_stream.dest_slice  = out_slice_reg;
    assign pixel_stream.dest_outer  = out_outer_reg;
    assign pixel_stream.dest_inner  = out_inner_reg;
    assign pixel_stream.last_pixel  = out_last_reg;

endmodule

/* rtl/raw_pixel_assemble_rotate.sv */
// Top level of the raw pixel assemble and rotate block.
// Depends on rpar_pkg, rpar_ifs, rpar_cfg and rpar_core.

// The block takes a raw image file one byte per transaction, skips header_bytes
// leading bytes, packs every bytes_per_pixel bytes (1 to 4, first byte most significant
// unless little_endian is set) into a 32-bit pixel, and emits each pixel with its slice
// index and its row and column after a clockwise rotation of 90, 180 or 270 degrees.
// Source order is inner index fastest (image_height), then outer index (image_width),
// then slice. The pixel that closes the last slice carries last_pixel; after it every
// byte is accepted and dropped until reset. Throughput is one byte per clock: each byte
// passes the skip counter, the packing shifter and the counter update combinationally,
// and a finished pixel lands in one output register in the cycle after its last byte.
// While that register holds a pixel the downstream side has not taken, bytes that do
// not complete a pixel are still accepted; only a byte that would complete one waits.
// Configuration is written through the APB port while the stream is idle, a rule for
// the user that the block does not enforce; writing header_bytes restarts the header
// skip, the pixel counters are kept otherwise. Register map (byte addresses):
// 0x00 header_bytes, 0x04 bytes_per_pixel, 0x08 little_endian, 0x0C image_width,
// 0x10 image_height, 0x14 slice_total, 0x18 rotation.
module raw_pixel_assemble_rotate
(
    input  logic                          clk,
    input  logic                          rst_n,
    rpar_byte_if.sink                     byte_stream,
    rpar_pix_if.source                    pixel_stream,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpar_pkg::ADDR_W-1:0]   paddr,
    input  logic [rpar_pkg::DATA_W-1:0]   pwdata,
    output logic [rpar_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    // Clamped settings and the header reload pulse travel as one bundle.
    rpar_pkg::cfg_t cfg;

    rpar_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // All per-byte work happens here between the state registers and the output register.
    rpar_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .byte_stream  (byte_stream),
        .pixel_stream (pixel_stream)
    );

endmodule

/* rtl/rpar_checker.sv */
// Port-level checks of the raw pixel assemble and rotate block, bound to its top level.
// Depends on rpar_pkg and raw_pixel_assemble_rotate.
module rpar_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rpar_pkg::PIX_W-1:0]    pixel_value,
    input logic                          last_pixel
);

    // A pixel waiting downstream keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_value))
        else $error("pixel dropped or changed while stalled");

    // A new pixel only appears right after a byte was taken.
    a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("pixel produced without an input byte");

    // Nothing follows the final pixel of the final slice.
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_pixel |=> !out_valid)
        else $error("pixel emitted after the last pixel");

endmodule

bind raw_pixel_assemble_rotate rpar_checker u_rpar_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (byte_stream.valid),
    .in_ready    (byte_stream.ready),
    .out_valid   (pixel_stream.valid),
    .out_ready   (pixel_stream.ready),
    .pixel_value (pixel_stream.pixel_value),
    .last_pixel  (pixel_stream.last_pixel)
);

/* test/testbench.sv */
// Self-checking testbench for raw_pixel_assemble_rotate: a directed script, random setting phases
// and a final run to the end of the stream, checked by a built-in predictor and typed pixels.
// Depends on rpar_pkg, rpar_ifs and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

    // One pixel as the block emits it, field for field.
    typedef struct packed {
        logic [rpar_pkg::PIX_W-1:0] value;
        logic [rpar_pkg::SLC_W-1:0] slice;
        logic [rpar_pkg::IDX_W-1:0] outer;
        logic [rpar_pkg::IDX_W-1:0] inner;
        logic                       last;
    } pixel_t;

    // A row of the directed script either writes a register or offers one byte. A byte row
    // may carry a pixel typed in by hand; that pixel is then expected instead of the
    // predicted one.
    typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t             op;
        rpar_pkg::reg_index_t  idx;
        logic [31:0]           value;
        bit                    typed;
        pixel_t                want;
    } script_row_t;

    localparam int RANDOM_BYTES   = 700;
    localparam int SETTLE_CYCLES  = 4;     // output register latency plus margin
    localparam int SQUEEZE_CYCLES = 120;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction

    logic clk;
    logic rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rpar_pkg::ADDR_W-1:0]   paddr;
    logic [rpar_pkg::DATA_W-1:0]   pwdata;
    logic [rpar_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    rpar_byte_if byte_if();
    rpar_pix_if  pix_if();

    raw_pixel_assemble_rotate dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_if),
        .pixel_stream (pix_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Predictor copy of the register file.
    logic [rpar_pkg::HDR_W-1:0]  hdr_cfg;
    logic [rpar_pkg::BPP_W-1:0]  bpp_cfg;
    logic                        le_cfg;
    logic [rpar_pkg::DIM_W-1:0]  width_cfg;
    logic [rpar_pkg::DIM_W-1:0]  height_cfg;
    logic [rpar_pkg::NSL_W-1:0]  slices_cfg;
    rpar_pkg::rotation_t         rot_cfg;

    // Predictor copy of the stream state.
    logic [rpar_pkg::HDR_W-1:0]  skip_left;
    logic [rpar_pkg::POS_W-1:0]  byte_pos;
    logic [rpar_pkg::PIX_W-1:0]  pixel_acc;
    logic [rpar_pkg::SLC_W-1:0]  slice_cnt;
    logic [rpar_pkg::IDX_W-1:0]  outer_cnt;
    logic [rpar_pkg::IDX_W-1:0]  inner_cnt;
    bit                          stream_done;

    pixel_t       awaited_pixels[$];
    script_row_t  script[$];

    int  mismatch_count;
    int  pixels_checked;
    int  last_pixels_seen;
    int  bytes_accepted;
    int  directed_bytes;
    int  random_bytes;
    int  ignored_bytes;
    int  phase_count;
    bit  steady_flow;     // no gaps on either side while set
    bit  squeeze_armed;   // asks the receiver for its one long hold-off

    // ------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    // Effective value of a size register: zero counts as one, anything above the
    // limit is held at the limit.
    function automatic int limit_to(input int v, input int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void reset_predictor();
        hdr_cfg     = '0;
        bpp_cfg     = rpar_pkg::BPP_W'(2);
        le_cfg      = 1'b0;
        width_cfg   = rpar_pkg::DIM_W'(512);
        height_cfg  = rpar_pkg::DIM_W'(512);
        slices_cfg  = rpar_pkg::NSL_W'(1);
        rot_cfg     = rpar_pkg::ROT_90;
        skip_left   = '0;
        byte_pos    = '0;
        pixel_acc   = '0;
        slice_cnt   = '0;
        outer_cnt   = '0;
        inner_cnt   = '0;
        stream_done = 1'b0;
    endfunction

    // Mirrors a register write. Bits above a register's width are dropped, and a
    // header write restarts the header skip from the new count.
    function automatic void store_register(input rpar_pkg::reg_index_t idx,
                                           input logic [31:0] value);
        case (idx)
            rpar_pkg::REG_HEADER_BYTES:
            begin
                hdr_cfg   = value[rpar_pkg::HDR_W-1:0];
                skip_left = value[rpar_pkg::HDR_W-1:0];
            end
            rpar_pkg::REG_BYTES_PER_PIXEL: bpp_cfg    = value[rpar_pkg::BPP_W-1:0];
            rpar_pkg::REG_LITTLE_ENDIAN:   le_cfg     = value[0];
            rpar_pkg::REG_IMAGE_WIDTH:     width_cfg  = value[rpar_pkg::DIM_W-1:0];
            rpar_pkg::REG_IMAGE_HEIGHT:    height_cfg = value[rpar_pkg::DIM_W-1:0];
            rpar_pkg::REG_SLICE_TOTAL:     slices_cfg = value[rpar_pkg::NSL_W-1:0];
            rpar_pkg::REG_ROTATION:        rot_cfg    = rpar_pkg::rotation_t'(value[1:0]);
            default: ;
        endcase
    endfunction

    // Takes one accepted byte through the header skip and the packing shifter. Returns 1
    // and the pixel when the byte completes one, and then advances the source position.
    function automatic bit absorb_byte(input logic [7:0] b, output pixel_t px);
        int  per_pixel;
        int  w;
        int  h;
        int  ns;
        int  d_outer;
        int  d_inner;
        bit  last_one;
        px       = '0;
        last_one = 1'b0;
        if (stream_done)
            return 1'b0;
        if (skip_left != 0)
        begin
            skip_left = skip_left - rpar_pkg::HDR_W'(1);
            return 1'b0;
        end

        per_pixel = limit_to(int'(bpp_cfg), int'(rpar_pkg::MAX_BYTES_PER_PIXEL));
        if (byte_pos == 0)
            pixel_acc = '0;
        if (le_cfg)
            pixel_acc = pixel_acc | ({24'd0, b} << (8 * byte_pos));
        else
            pixel_acc = {pixel_acc[rpar_pkg::PIX_W-9:0], b};

        if (int'(byte_pos) + 1 < per_pixel &&
            int'(byte_pos) + 1 < int'(rpar_pkg::MAX_BYTES_PER_PIXEL))
        begin
            byte_pos = byte_pos + rpar_pkg::POS_W'(1);
            return 1'b0;
        end
        byte_pos = '0;

        w  = limit_to(int'(width_cfg), int'(rpar_pkg::MAX_DIM));
        h  = limit_to(int'(height_cfg), int'(rpar_pkg::MAX_DIM));
        ns = limit_to(int'(slices_cfg), int'(rpar_pkg::MAX_SLICES));

        // A counter left beyond a shrunken size gives a negative index here; the
        // low bits of it are what the block emits.
        case (rot_cfg)
            rpar_pkg::ROT_180:
            begin
                d_outer = w - 1 - int'(outer_cnt);
                d_inner = h - 1 - int'(inner_cnt);
            end
            rpar_pkg::ROT_270:
            begin
                d_outer = int'(inner_cnt);
                d_inner = w - 1 - int'(outer_cnt);
            end
            default:
            begin
                d_outer = h - 1 - int'(inner_cnt);
                d_inner = int'(outer_cnt);
            end
        endcase

        px.value = pixel_acc;
        px.slice = slice_cnt;
        px.outer = d_outer[rpar_pkg::IDX_W-1:0];
        px.inner = d_inner[rpar_pkg::IDX_W-1:0];

        if (int'(inner_cnt) + 1 >= h)
        begin
            inner_cnt = '0;
            if (int'(outer_cnt) + 1 >= w)
            begin
                outer_cnt = '0;
                if (int'(slice_cnt) + 1 >= ns)
                begin
                    slice_cnt   = '0;
                    stream_done = 1'b1;
                    last_one    = 1'b1;
                end
                else
                    slice_cnt = slice_cnt + rpar_pkg::SLC_W'(1);
            end
            else
                outer_cnt = outer_cnt + rpar_pkg::IDX_W'(1);
        end
        else
            inner_cnt = inner_cnt + rpar_pkg::IDX_W'(1);

        px.last = last_one;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random choices.
    // ------------------------------------------------------------------

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Image sizes are small most of the time so that slices turn over often; now and
    // then a zero, the maximum or a value past it shows up.
    function automatic logic [31:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'd4096;
        if (r == 2)
            return 32'd8191;
        if (r == 3)
            return $urandom_range(6, 8191);
        return $urandom_range(1, 5);
    endfunction

    // Sometimes sets junk above the register's width; the block must drop it.
    function automatic logic [31:0] with_noise(input logic [31:0] v, input int field_w);
        if ($urandom_range(0, 3) == 0)
            return v | ($urandom << field_w);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int index,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("pixel %0d %s is 0x%0h, expected 0x%0h",
                                      index, name, got, want));
    endtask

    // Every pixel transaction is compared with the oldest awaited pixel.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n === 1'b1 && pix_if.valid === 1'b1 && pix_if.ready === 1'b1)
        begin
            if (awaited_pixels.size() == 0)
                report_mismatch($sformatf("pixel %0d arrived with none awaited",
                                          pixels_checked));
            else
            begin
                want = awaited_pixels.pop_front();
                check_field("pixel_value", pixels_checked, pix_if.pixel_value, want.value);
                check_field("dest_slice", pixels_checked,
                            32'(pix_if.dest_slice), 32'(want.slice));
                check_field("dest_outer", pixels_checked,
                            32'(pix_if.dest_outer), 32'(want.outer));
                check_field("dest_inner", pixels_checked,
                            32'(pix_if.dest_inner), 32'(want.inner));
                check_field("last_pixel", pixels_checked,
                            32'(pix_if.last_pixel), 32'(want.last));
            end
            if (pix_if.last_pixel === 1'b1)
                last_pixels_seen++;
            pixels_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Pixel receiver. Ready drops for random stretches. Once, when asked, it holds off
    // for a long stretch while bytes keep coming, so the output register fills and the
    // block has to stall its input.
    // ------------------------------------------------------------------
    initial
    begin : pixel_receiver
        int  gap;
        bit  squeeze_done;
        squeeze_done = 1'b0;
        pix_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_armed && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                pix_if.ready = 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                pix_if.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                pix_if.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a quiet counter counts up while no transaction of any kind happens and
    // clears on any; when it reaches WATCHDOG_LIMIT the run is ended as a failure.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
                (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) ||
                (psel === 1'b1 && penable === 1'b1) || rst_n !== 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles, %0d pixels still awaited",
                 WATCHDOG_LIMIT, awaited_pixels.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------

    // Offers one byte after a random idle stretch and waits for the block to take it.
    // The predictor sees the byte at the edge that accepts it.
    task automatic push_byte(input logic [7:0] b, output bit made, output pixel_t px);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            byte_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_if.valid     = 1'b1;
        byte_if.data_byte = b;
        do
            @(posedge clk);
        while (byte_if.ready !== 1'b1);
        made = absorb_byte(b, px);
        bytes_accepted++;
        if (stream_done && !made)
            ignored_bytes++;
    endtask

    task automatic push_random_byte();
        bit      made;
        pixel_t  px;
        push_byte(pick_byte(), made, px);
        if (made)
            awaited_pixels.push_back(px);
    endtask

    // Stops offering bytes and waits until every awaited pixel has arrived, then waits out
    // SETTLE_CYCLES for the output register, so that registers are written while idle.
    task automatic settle_stream();
        @(negedge clk);
        byte_if.valid = 1'b0;
        while (awaited_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(input rpar_pkg::reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        store_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Script building.
    task automatic add_write(input rpar_pkg::reg_index_t idx, input logic [31:0] value);
        script_row_t row;
        row       = '{ROW_WRITE, idx, value, 1'b0, '0};
        script.push_back(row);
    endtask

    task automatic add_byte(input logic [7:0] b);
        script_row_t row;
        row       = '{ROW_BYTE, rpar_pkg::REG_HEADER_BYTES, {24'd0, b}, 1'b0, '0};
        script.push_back(row);
    endtask

    task automatic add_pixel(input logic [7:0] b, input logic [31:0] value, input int slice,
                             input int outer, input int inner, input bit last);
        script_row_t row;
        pixel_t      want;
        want.value = value;
        want.slice = rpar_pkg::SLC_W'(slice);
        want.outer = rpar_pkg::IDX_W'(outer);
        want.inner = rpar_pkg::IDX_W'(inner);
        want.last  = last;
        row        = '{ROW_BYTE, rpar_pkg::REG_HEADER_BYTES, {24'd0, b}, 1'b1, want};
        script.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        bit      made;
        pixel_t  px;
        int      n;

        rst_n             = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'h00;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        steady_flow       = 1'b0;
        squeeze_armed     = 1'b0;
        mismatch_count    = 0;
        pixels_checked    = 0;
        last_pixels_seen  = 0;
        bytes_accepted    = 0;
        directed_bytes    = 0;
        random_bytes      = 0;
        ignored_bytes     = 0;
        phase_count       = 0;
        reset_predictor();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed script. It starts from the reset settings (two bytes per pixel, first
        // byte most significant, 512 by 512, 90 degrees), so the first pixels land at the
        // bottom of the first column of the rotated slice.
        add_byte(8'h12);
        add_pixel(8'h34, 32'h0000_1234, 0, 511, 0, 0);
        add_byte(8'hFF);
        add_pixel(8'hFF, 32'h0000_FFFF, 0, 510, 0, 0);
        // Widest pixel in little endian order.
        add_write(rpar_pkg::REG_BYTES_PER_PIXEL, 32'd4);
        add_write(rpar_pkg::REG_LITTLE_ENDIAN, 32'd1);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_pixel(8'hFF, 32'hFF00_FF00, 0, 509, 0, 0);
        // Out of range sizes: zero bytes per pixel acts as one, a zero width as one and a
        // height past the limit as the limit. Then 180 degrees.
        add_write(rpar_pkg::REG_BYTES_PER_PIXEL, 32'd0);
        add_write(rpar_pkg::REG_LITTLE_ENDIAN, 32'd0);
        add_write(rpar_pkg::REG_ROTATION, rpar_pkg::ROT_180);
        add_write(rpar_pkg::REG_IMAGE_WIDTH, 32'd0);
        add_write(rpar_pkg::REG_IMAGE_HEIGHT, 32'd8191);
        add_pixel(8'hAA, 32'h0000_00AA, 0, 0, 4092, 0);
        // Bytes per pixel past the limit acts as four; the top bit of the pixel must come
        // out as a plain unsigned bit. 270 degrees.
        add_write(rpar_pkg::REG_BYTES_PER_PIXEL, 32'd7);
        add_write(rpar_pkg::REG_ROTATION, rpar_pkg::ROT_270);
        add_byte(8'h80);
        add_byte(8'h00);
        add_byte(8'h00);
        add_pixel(8'h01, 32'h8000_0001, 0, 4, 0, 0);
        // The unused rotation code behaves as 90 degrees; three header bytes are skipped.
        add_write(rpar_pkg::REG_ROTATION, rpar_pkg::ROT_ALT);
        add_write(rpar_pkg::REG_BYTES_PER_PIXEL, 32'd1);
        add_write(rpar_pkg::REG_HEADER_BYTES, 32'd3);
        add_byte(8'h11);
        add_byte(8'h22);
        add_byte(8'h33);
        add_pixel(8'h44, 32'h0000_0044, 0, 4090, 0, 0);
        // Largest header count, then a rewrite to one: the skip starts over.
        add_write(rpar_pkg::REG_HEADER_BYTES, 32'hFFFF);
        add_byte(8'h55);
        add_byte(8'h66);
        add_write(rpar_pkg::REG_HEADER_BYTES, 32'd1);
        add_byte(8'h77);
        add_byte(8'h88);
        // Height shrunk below the inner counter: the rotated index wraps and the counter
        // rolls over on that same pixel. Slice total past its limit.
        add_write(rpar_pkg::REG_IMAGE_HEIGHT, 32'd1);
        add_write(rpar_pkg::REG_IMAGE_WIDTH, 32'd4096);
        add_write(rpar_pkg::REG_SLICE_TOTAL, 32'd2047);
        add_byte(8'h99);
        // A two pixel slice turned 180 degrees, so a slice boundary is crossed.
        add_write(rpar_pkg::REG_IMAGE_HEIGHT, 32'd0);
        add_write(rpar_pkg::REG_ROTATION, rpar_pkg::ROT_180);
        add_write(rpar_pkg::REG_IMAGE_WIDTH, 32'd2);
        add_write(rpar_pkg::REG_SLICE_TOTAL, 32'd1024);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(8'h5A);

        foreach (script[k])
        begin
            if (script[k].op == ROW_WRITE)
            begin
                settle_stream();
                write_register(script[k].idx, script[k].value);
            end
            else
            begin
                push_byte(script[k].value[7:0], made, px);
                directed_bytes++;
                if (script[k].typed)
                    awaited_pixels.push_back(script[k].want);
                else if (made)
                    awaited_pixels.push_back(px);
            end
        end

        // Random phases. Each one writes every register with fresh settings while the
        // block is idle and then streams random bytes. The slice total stays at the top
        // of its range here so that the stream cannot end before the last phase.
        // Phase 2 runs with no gaps on either side; phase 3 carries the long
        // receiver hold-off.
        while (random_bytes < RANDOM_BYTES)
        begin
            settle_stream();
            steady_flow = (phase_count == 2);
            write_register(rpar_pkg::REG_HEADER_BYTES, with_noise(
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0, rpar_pkg::HDR_W));
            write_register(rpar_pkg::REG_BYTES_PER_PIXEL,
                           with_noise($urandom_range(0, 7), rpar_pkg::BPP_W));
            write_register(rpar_pkg::REG_LITTLE_ENDIAN, with_noise($urandom_range(0, 1), 1));
            write_register(rpar_pkg::REG_IMAGE_WIDTH, with_noise(pick_dim(), rpar_pkg::DIM_W));
            write_register(rpar_pkg::REG_IMAGE_HEIGHT, with_noise(pick_dim(), rpar_pkg::DIM_W));
            write_register(rpar_pkg::REG_SLICE_TOTAL,
                           with_noise($urandom_range(1024, 2047), rpar_pkg::NSL_W));
            write_register(rpar_pkg::REG_ROTATION, with_noise($urandom_range(0, 3), 2));
            if (phase_count == 3)
                squeeze_armed = 1'b1;
            n = $urandom_range(60, 140);
            repeat (n)
            begin
                push_random_byte();
                random_bytes++;
            end
            phase_count++;
        end

        // Final phase: a tiny image and a slice total of zero (taken as one), so the
        // current slice is the last. Bytes go in until the last pixel is predicted, and 16 more
        // must then vanish without a pixel.
        settle_stream();
        steady_flow = 1'b0;
        write_register(rpar_pkg::REG_HEADER_BYTES, $urandom_range(0, 2));
        write_register(rpar_pkg::REG_BYTES_PER_PIXEL, $urandom_range(0, 7));
        write_register(rpar_pkg::REG_LITTLE_ENDIAN, $urandom_range(0, 1));
        write_register(rpar_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 3));
        write_register(rpar_pkg::REG_IMAGE_HEIGHT, $urandom_range(1, 3));
        write_register(rpar_pkg::REG_ROTATION, $urandom_range(0, 3));
        write_register(rpar_pkg::REG_SLICE_TOTAL, 32'd0);
        while (!stream_done)
            push_random_byte();
        repeat (16) push_random_byte();

        settle_stream();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d bytes accepted (%0d directed, %0d random, %0d after stream end)",
                 bytes_accepted, directed_bytes, random_bytes, ignored_bytes);
        $display("summary: %0d pixels checked over %0d random phases, %0d last pixel, %0d %s",
                 pixels_checked, phase_count, last_pixels_seen, mismatch_count, "mismatches");
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
